// File: rtl/core/bcdlru_pkg.sv
// ----------------------------------------------------------------------------
// bcdlru_pkg
// Shared types, widths and helpers for the block cache directory with
// release-time replacement.
// ----------------------------------------------------------------------------
package bcdlru_pkg;

  // sizing
  localparam int NumBuffers = 32;
  localparam int NumBuckets = 13;

  // field widths
  localparam int FuncW   = 2;
  localparam int DevW    = 8;
  localparam int BlockW  = 32;
  localparam int SelW    = 5;
  localparam int TimeW   = 32;
  localparam int StatusW = 2;
  localparam int RefW    = 8;
  localparam int RankW   = 32;

  // derived widths
  localparam int IdxW    = (NumBuffers > 1) ? $clog2(NumBuffers) : 1;
  localparam int CntW    = $clog2(NumBuffers + 1);
  localparam int BucketW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int CmpW    = (IdxW > SelW) ? IdxW : SelW;
  localparam int NibW    = 4;
  localparam int ModW    = BucketW + NibW;
  localparam int NibCnt  = BlockW / NibW;
  localparam int NibCntW = (NibCnt > 1) ? $clog2(NibCnt) : 1;

  localparam logic [RefW-1:0] RefMax = {RefW{1'b1}};

  // request codes
  typedef enum logic [FuncW-1:0] {
    FuncGet     = 2'd0,
    FuncRelease = 2'd1,
    FuncPin     = 2'd2,
    FuncUnpin   = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk        = 2'd0,
    StatusNoBuffer  = 2'd1,
    StatusCountZero = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StLaunch,
    StScan,
    StDeliver
  } state_e;

  // request token walking down the chain, with what it has gathered so far
  typedef struct packed {
    logic                valid;
    func_e               func;
    logic [DevW-1:0]     dev;
    logic [BlockW-1:0]   blk;
    logic [BucketW-1:0]  home;
    logic [SelW-1:0]     sel;
    logic [TimeW-1:0]    now;
    logic                hit;
    logic [IdxW-1:0]     hit_idx;
    logic                nread;
    status_e             status;
    logic                vic_found;
    logic                vic_home;
    logic [BucketW-1:0]  vic_bucket;
    logic [TimeW-1:0]    vic_rt;
    logic [RankW-1:0]    vic_rank;
    logic [IdxW-1:0]     vic_idx;
  } tok_t;

  // placement write broadcast to all entries
  typedef struct packed {
    logic                valid;
    logic [IdxW-1:0]     idx;
    logic [DevW-1:0]     dev;
    logic [BlockW-1:0]   blk;
    logic [BucketW-1:0]  bucket;
    logic                new_rank;
    logic [RankW-1:0]    rank;
  } place_t;

  // one nibble of a modulo-bucket-count reduction, msb first
  function automatic logic [BucketW-1:0] mod_step(input logic [BucketW-1:0] rem,
                                                   input logic [NibW-1:0] nib);
    logic [ModW-1:0] x;
    logic [ModW-1:0] m;
    x = {rem, nib};
    for (int k = NibW - 1; k >= 0; k--) begin
      m = ModW'(NumBuckets) << k;
      if (x >= m) begin
        x = x - m;
      end
    end
    return x[BucketW-1:0];
  endfunction

endpackage

// File: rtl/core/bcdlru_cell.sv
// ----------------------------------------------------------------------------
// bcdlru_cell
// One directory entry. Checks the passing request token against its entry,
// applies count changes addressed to it and hands the token on.
// ----------------------------------------------------------------------------
module bcdlru_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [bcdlru_pkg::IdxW-1:0]        cell_idx_i,
  input  bcdlru_pkg::tok_t                   tok_i,
  input  bcdlru_pkg::place_t                 place_i,
  output bcdlru_pkg::tok_t                   tok_o
);

  // entry state
  logic                              used_q, used_d;
  logic                              valid_q, valid_d;
  logic [bcdlru_pkg::RefW-1:0]       ref_q, ref_d;
  logic [bcdlru_pkg::TimeW-1:0]      rt_q, rt_d;
  logic [bcdlru_pkg::DevW-1:0]       dev_q, dev_d;
  logic [bcdlru_pkg::BlockW-1:0]     blk_q, blk_d;
  logic [bcdlru_pkg::BucketW-1:0]    bucket_q, bucket_d;
  logic [bcdlru_pkg::RankW-1:0]      rank_q, rank_d;
  bcdlru_pkg::tok_t                  tok_q, tok_d;

  logic sel_match, place_match, tag_match, qualify, cand_home, older, better;

  // match and victim ranking terms
  assign sel_match   = bcdlru_pkg::CmpW'(cell_idx_i) == bcdlru_pkg::CmpW'(tok_i.sel);
  assign place_match = place_i.valid && (place_i.idx == cell_idx_i);
  assign tag_match   = used_q && (dev_q == tok_i.dev) && (blk_q == tok_i.blk);
  assign qualify     = used_q && (ref_q == '0) && (rt_q < tok_i.now);
  assign cand_home   = bucket_q == tok_i.home;
  assign older       = (rt_q < tok_i.vic_rt) ||
                       ((rt_q == tok_i.vic_rt) && (rank_q > tok_i.vic_rank));
  assign better      = !tok_i.vic_found ||
                       (cand_home && !tok_i.vic_home) ||
                       ((cand_home == tok_i.vic_home) &&
                        ((bucket_q < tok_i.vic_bucket) ||
                         ((bucket_q == tok_i.vic_bucket) && older)));

  // token update and entry writes
  always_comb begin
    tok_d    = tok_i;
    used_d   = used_q;
    valid_d  = valid_q;
    ref_d    = ref_q;
    rt_d     = rt_q;
    dev_d    = dev_q;
    blk_d    = blk_q;
    bucket_d = bucket_q;
    rank_d   = rank_q;

    if (tok_i.valid) begin
      case (tok_i.func)
        bcdlru_pkg::FuncGet: begin
          if (!tok_i.hit && tag_match) begin
            tok_d.hit     = 1'b1;
            tok_d.hit_idx = cell_idx_i;
            tok_d.nread   = !valid_q;
            valid_d       = 1'b1;
            if (ref_q != bcdlru_pkg::RefMax) begin
              ref_d = ref_q + bcdlru_pkg::RefW'(1);
            end
          end else if (!tok_i.hit && qualify && better) begin
            tok_d.vic_found  = 1'b1;
            tok_d.vic_home   = cand_home;
            tok_d.vic_bucket = bucket_q;
            tok_d.vic_rt     = rt_q;
            tok_d.vic_rank   = rank_q;
            tok_d.vic_idx    = cell_idx_i;
          end
        end
        bcdlru_pkg::FuncPin: begin
          if (sel_match) begin
            tok_d.status = bcdlru_pkg::StatusOk;
            if (ref_q != bcdlru_pkg::RefMax) begin
              ref_d = ref_q + bcdlru_pkg::RefW'(1);
            end
          end
        end
        bcdlru_pkg::FuncRelease, bcdlru_pkg::FuncUnpin: begin
          if (sel_match) begin
            if (ref_q == '0) begin
              tok_d.status = bcdlru_pkg::StatusCountZero;
            end else begin
              tok_d.status = bcdlru_pkg::StatusOk;
              ref_d        = ref_q - bcdlru_pkg::RefW'(1);
              // last reference gone: stamp the release time
              if ((tok_i.func == bcdlru_pkg::FuncRelease) &&
                  (ref_q == bcdlru_pkg::RefW'(1))) begin
                rt_d = tok_i.now;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // placement of a new block into this entry
    if (place_match) begin
      used_d   = 1'b1;
      valid_d  = 1'b1;
      ref_d    = bcdlru_pkg::RefW'(1);
      dev_d    = place_i.dev;
      blk_d    = place_i.blk;
      bucket_d = place_i.bucket;
      if (place_i.new_rank) begin
        rank_d = place_i.rank;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      valid_q <= 1'b0;
      ref_q   <= '0;
      rt_q    <= '0;
      tok_q   <= '0;
    end else begin
      used_q  <= used_d;
      valid_q <= valid_d;
      ref_q   <= ref_d;
      rt_q    <= rt_d;
      tok_q   <= tok_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    dev_q    <= dev_d;
    blk_q    <= blk_d;
    bucket_q <= bucket_d;
    rank_q   <= rank_d;
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/block_cache_directory_lru_unit.sv
// ----------------------------------------------------------------------------
// block_cache_directory_lru_unit
// Directory of disk-block buffers with hashed buckets and release-time
// replacement. Takes one request at a time: get, release, pin or unpin.
// A request first reduces the block number modulo the bucket count, one
// nibble per cycle. The request token is then launched into the first of
// the 32 entry cells and passes down the chain, collecting the tag hit and
// the best victim on the way. The placement is decided and written as the
// token leaves the chain, and the result then moves to the output register.
// The input is ready again once the result has moved there. A result still
// waiting in the output register holds the next result, and with it the
// input, until it is taken.
// The entries are cleared by reset itself, no clearing pass.
// ----------------------------------------------------------------------------
module block_cache_directory_lru_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bcdlru_pkg::FuncW-1:0]    func_i,
  input  logic [bcdlru_pkg::DevW-1:0]     device_i,
  input  logic [bcdlru_pkg::BlockW-1:0]   block_number_i,
  input  logic [bcdlru_pkg::SelW-1:0]     buffer_select_i,
  input  logic [bcdlru_pkg::TimeW-1:0]    now_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bcdlru_pkg::SelW-1:0]     buffer_index_o,
  output logic                            hit_o,
  output logic                            needs_read_o,
  output logic [bcdlru_pkg::StatusW-1:0]  status_o
);

  bcdlru_pkg::state_e                   state_q, state_d;

  // captured request
  bcdlru_pkg::func_e                    func_q;
  logic [bcdlru_pkg::DevW-1:0]          dev_q;
  logic [bcdlru_pkg::BlockW-1:0]        blk_q;
  logic [bcdlru_pkg::SelW-1:0]          sel_q;
  logic [bcdlru_pkg::TimeW-1:0]         now_q;

  // home bucket reduction
  logic [bcdlru_pkg::BlockW-1:0]        mod_sh_q;
  logic [bcdlru_pkg::BucketW-1:0]       rem_q;
  logic [bcdlru_pkg::NibCntW-1:0]       nib_cnt_q, nib_cnt_d;

  // directory counters
  logic [bcdlru_pkg::CntW-1:0]          used_cnt_q, used_cnt_d;
  logic [bcdlru_pkg::RankW-1:0]         rank_cnt_q, rank_cnt_d;

  // pending result and output register
  logic [bcdlru_pkg::SelW-1:0]          res_idx_q, res_idx_d;
  logic                                 res_hit_q, res_hit_d;
  logic                                 res_nread_q, res_nread_d;
  bcdlru_pkg::status_e                  res_status_q, res_status_d;
  logic                                 out_load;
  logic                                 out_valid_q;
  logic [bcdlru_pkg::SelW-1:0]          out_idx_q;
  logic                                 out_hit_q;
  logic                                 out_nread_q;
  bcdlru_pkg::status_e                  out_status_q;

  logic                                 in_accept;
  bcdlru_pkg::tok_t                     launch_tok;
  bcdlru_pkg::tok_t                     exit_tok;
  bcdlru_pkg::place_t                   place;
  bcdlru_pkg::tok_t                     chain_tok [bcdlru_pkg::NumBuffers+1];

  assign in_ready_o = state_q == bcdlru_pkg::StIdle;
  assign in_accept  = in_valid_i && in_ready_o;
  assign exit_tok   = chain_tok[bcdlru_pkg::NumBuffers];
  assign chain_tok[0] = launch_tok;

  // chain of entry cells, token moves one cell per cycle
  for (genvar g = 0; g < bcdlru_pkg::NumBuffers; g++) begin : g_cell
    bcdlru_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (bcdlru_pkg::IdxW'(g)),
      .tok_i      (chain_tok[g]),
      .place_i    (place),
      .tok_o      (chain_tok[g+1])
    );
  end

  // sequencer: next state, token launch, decision and placement
  always_comb begin
    state_d      = state_q;
    nib_cnt_d    = nib_cnt_q;
    used_cnt_d   = used_cnt_q;
    rank_cnt_d   = rank_cnt_q;
    res_idx_d    = res_idx_q;
    res_hit_d    = res_hit_q;
    res_nread_d  = res_nread_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    launch_tok   = '0;
    place        = '0;

    case (state_q)
      bcdlru_pkg::StIdle: begin
        if (in_valid_i) begin
          nib_cnt_d = '0;
          state_d   = bcdlru_pkg::StMod;
        end
      end
      bcdlru_pkg::StMod: begin
        nib_cnt_d = nib_cnt_q + bcdlru_pkg::NibCntW'(1);
        if (nib_cnt_q == bcdlru_pkg::NibCntW'(bcdlru_pkg::NibCnt - 1)) begin
          state_d = bcdlru_pkg::StLaunch;
        end
      end
      bcdlru_pkg::StLaunch: begin
        launch_tok.valid  = 1'b1;
        launch_tok.func   = func_q;
        launch_tok.dev    = dev_q;
        launch_tok.blk    = blk_q;
        launch_tok.home   = rem_q;
        launch_tok.sel    = sel_q;
        launch_tok.now    = now_q;
        // an unmatched select leaves the count-zero status standing
        launch_tok.status = (func_q == bcdlru_pkg::FuncGet) ? bcdlru_pkg::StatusOk
                                                            : bcdlru_pkg::StatusCountZero;
        state_d = bcdlru_pkg::StScan;
      end
      bcdlru_pkg::StScan: begin
        if (exit_tok.valid) begin
          state_d      = bcdlru_pkg::StDeliver;
          res_hit_d    = 1'b0;
          res_nread_d  = 1'b0;
          res_status_d = bcdlru_pkg::StatusOk;
          res_idx_d    = exit_tok.sel;
          if (exit_tok.func == bcdlru_pkg::FuncGet) begin
            place.dev    = exit_tok.dev;
            place.blk    = exit_tok.blk;
            place.bucket = exit_tok.home;
            place.rank   = rank_cnt_q + bcdlru_pkg::RankW'(1);
            if (exit_tok.hit) begin
              res_idx_d   = bcdlru_pkg::SelW'(exit_tok.hit_idx);
              res_hit_d   = 1'b1;
              res_nread_d = exit_tok.nread;
            end else if (used_cnt_q < bcdlru_pkg::CntW'(bcdlru_pkg::NumBuffers)) begin
              // a never-used entry is free
              place.valid    = 1'b1;
              place.idx      = bcdlru_pkg::IdxW'(used_cnt_q);
              place.new_rank = 1'b1;
              used_cnt_d     = used_cnt_q + bcdlru_pkg::CntW'(1);
              rank_cnt_d     = rank_cnt_q + bcdlru_pkg::RankW'(1);
              res_idx_d      = bcdlru_pkg::SelW'(used_cnt_q);
              res_nread_d    = 1'b1;
            end else if (exit_tok.vic_found) begin
              // recycle; moving across buckets takes a fresh rank
              place.valid    = 1'b1;
              place.idx      = exit_tok.vic_idx;
              place.new_rank = !exit_tok.vic_home;
              if (!exit_tok.vic_home) begin
                rank_cnt_d = rank_cnt_q + bcdlru_pkg::RankW'(1);
              end
              res_idx_d   = bcdlru_pkg::SelW'(exit_tok.vic_idx);
              res_nread_d = 1'b1;
            end else begin
              res_idx_d    = '0;
              res_status_d = bcdlru_pkg::StatusNoBuffer;
            end
          end else begin
            res_status_d = exit_tok.status;
          end
        end
      end
      bcdlru_pkg::StDeliver: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bcdlru_pkg::StIdle;
        end
      end
      default: begin
        state_d = bcdlru_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcdlru_pkg::StIdle;
      nib_cnt_q   <= '0;
      used_cnt_q  <= '0;
      rank_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nib_cnt_q  <= nib_cnt_d;
      used_cnt_q <= used_cnt_d;
      rank_cnt_q <= rank_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture and home bucket reduction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= bcdlru_pkg::func_e'(func_i);
      dev_q    <= device_i;
      blk_q    <= block_number_i;
      sel_q    <= buffer_select_i;
      now_q    <= now_i;
      mod_sh_q <= block_number_i;
      rem_q    <= '0;
    end else if (state_q == bcdlru_pkg::StMod) begin
      rem_q    <= bcdlru_pkg::mod_step(rem_q,
                    mod_sh_q[bcdlru_pkg::BlockW-1 -: bcdlru_pkg::NibW]);
      mod_sh_q <= mod_sh_q << bcdlru_pkg::NibW;
    end
  end

  // result and output beat
  always_ff @(posedge clk_i) begin
    res_idx_q    <= res_idx_d;
    res_hit_q    <= res_hit_d;
    res_nread_q  <= res_nread_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_idx_q    <= res_idx_q;
      out_hit_q    <= res_hit_q;
      out_nread_q  <= res_nread_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign buffer_index_o = out_idx_q;
  assign hit_o          = out_hit_q;
  assign needs_read_o   = out_nread_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  // the token leaves the chain only while the sequencer waits for it
  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok.valid |-> (state_q == bcdlru_pkg::StScan))
    else $error("token left the chain outside the scan state");

  // placement only for a get that missed
  a_place_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place.valid |-> (exit_tok.valid && (exit_tok.func == bcdlru_pkg::FuncGet) &&
                     !exit_tok.hit))
    else $error("placement without a missing get");

  // fill count never passes the entry count
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= bcdlru_pkg::CntW'(bcdlru_pkg::NumBuffers))
    else $error("fill count beyond entry count");

  // a fresh rank advances the placement counter by one
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (place.valid && place.new_rank) |=>
      (rank_cnt_q == ($past(rank_cnt_q) + bcdlru_pkg::RankW'(1))))
    else $error("placement counter did not advance");
`endif

endmodule
